[rtl/core/stm_pkg.sv]
package stm_pkg;

    localparam int MAX_REQUESTS = 1024;
    localparam int MAX_OFFERS   = 1024;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 11;
    localparam int REQ_AW       = $clog2(MAX_REQUESTS);
    localparam int OFF_AW       = $clog2(MAX_OFFERS);

    localparam logic [1:0] MODE_REQ = 2'd0;
    localparam logic [1:0] MODE_OFF = 2'd1;
    localparam logic [1:0] MODE_RUN = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic             overflow_seen;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_RUN_CHK,
        S_RUN_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic cap;
        logic put_val;
        logic rd_prev;
        logic shift;
        logic run_rd;
        logic run_cmp;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic gt;
        logic run_end;
    } t_sts;

endpackage

[rtl/core/sorted_tolerance_matcher_unit.sv]
// Sorted tolerance matcher.
// Command channel: a word (mode, item_value) is taken on a rising edge with
// start high and busy low. Mode 0 loads a request, mode 1 an offer, mode 2
// runs the match; mode 3 is taken and ignored.
// A load keeps its list ascending by insertion: walk down from the tail,
// a read step and a compare/write step per entry moved; the value is
// written in the compare/write step that stops the walk, or in the read
// step when it lands at the head of the list.
// A load into a full list is dropped in the accept cycle and flagged.
// A run walks both lists with two pointers, each step a RAM read, then a
// compare, at most count_req + count_off steps; then an end check and an
// emit step.
// The result word shows on o_res with o_res_strobe high for exactly one
// cycle, in the first cycle with busy low; the receiver cannot stall it.
// The run then empties both lists and clears the overflow flag.
// Configuration: the tolerance register takes a word whenever i_cfg_valid is
// high; o_cfg_ready is always high. Write it only while idle.
// Reset (synchronous, active low) empties both lists, clears the flag and
// the tolerance; list RAM contents are left as they are.
module sorted_tolerance_matcher_unit
    import stm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_cmd,
    output logic             o_res_strobe,
    output t_out             o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VAL_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic acc;

    // take a word only while the controller rests
    assign acc         = start && !busy;
    assign o_cfg_ready = 1'b1;

    stm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_mode  (i_cmd.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    stm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in       (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_strobe   (o_res_strobe),
        .o_res      (o_res)
    );

endmodule

[rtl/core/stm_ram.sv]
module stm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/stm_ctrl.sv]
module stm_ctrl
    import stm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [1:0] i_mode,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_acc) begin
                    if (i_mode == MODE_RUN) begin
                        n_state = S_RUN_CHK;
                    end else if ((i_mode inside {MODE_REQ, MODE_OFF}) && !i_sts.full) begin
                        n_state = S_INS_CHK;
                    end
                end
            end
            S_INS_CHK: n_state = i_sts.pos_zero ? S_IDLE : S_INS_CMP;
            S_INS_CMP: n_state = i_sts.gt ? S_INS_CHK : S_IDLE;
            S_RUN_CHK: n_state = i_sts.run_end ? S_EMIT : S_RUN_CMP;
            S_RUN_CMP: n_state = S_RUN_CHK;
            S_EMIT:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:    o_cmd.cap = i_acc;
            S_INS_CHK: begin
                o_cmd.put_val = i_sts.pos_zero;
                o_cmd.rd_prev = !i_sts.pos_zero;
            end
            S_INS_CMP: begin
                o_cmd.shift   = i_sts.gt;
                o_cmd.put_val = !i_sts.gt;
            end
            S_RUN_CHK: o_cmd.run_rd = !i_sts.run_end;
            S_RUN_CMP: o_cmd.run_cmp = 1'b1;
            S_EMIT:    o_cmd.emit = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/core/stm_dp.sv]
module stm_dp
    import stm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in              i_in,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_data,
    output t_sts             o_sts,
    output logic             o_strobe,
    output t_out             o_res
);

    logic [VAL_W-1:0] r_tol;
    logic [VAL_W-1:0] r_val;
    logic             r_sel;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_req_cnt;
    logic [CNT_W-1:0] r_off_cnt;
    logic             r_ovf;
    logic [CNT_W-1:0] r_a;
    logic [CNT_W-1:0] r_b;
    logic [CNT_W-1:0] r_hits;
    logic             r_strobe;
    t_out             r_res;

    logic [VAL_W-1:0] req_rdata, off_rdata, sel_rdata, wdata, diff;
    logic [CNT_W-1:0] pos_m1;
    logic             wr, full_in;

    assign sel_rdata = r_sel ? off_rdata : req_rdata;
    assign pos_m1    = r_pos - 1'b1;
    assign wr        = i_cmd.put_val | i_cmd.shift;
    assign wdata     = i_cmd.put_val ? r_val : sel_rdata;
    assign diff      = (req_rdata > off_rdata) ? (req_rdata - off_rdata)
                                               : (off_rdata - req_rdata);

    always_comb begin
        full_in = 1'b0;
        if (i_in.mode == MODE_REQ) begin
            full_in = (r_req_cnt == CNT_W'(MAX_REQUESTS));
        end else if (i_in.mode == MODE_OFF) begin
            full_in = (r_off_cnt == CNT_W'(MAX_OFFERS));
        end
    end

    stm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_REQUESTS)) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (wr && !r_sel),
        .i_waddr (r_pos[REQ_AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (i_cmd.run_rd ? r_a[REQ_AW-1:0] : pos_m1[REQ_AW-1:0]),
        .o_rdata (req_rdata)
    );

    stm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_OFFERS)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (wr && r_sel),
        .i_waddr (r_pos[OFF_AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (i_cmd.run_rd ? r_b[OFF_AW-1:0] : pos_m1[OFF_AW-1:0]),
        .o_rdata (off_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= '0;
            r_req_cnt <= '0;
            r_off_cnt <= '0;
            r_ovf     <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (i_cmd.cap && full_in) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.put_val) begin
                if (r_sel) begin
                    r_off_cnt <= r_off_cnt + 1'b1;
                end else begin
                    r_req_cnt <= r_req_cnt + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_req_cnt <= '0;
                r_off_cnt <= '0;
                r_ovf     <= 1'b0;
            end
        end
    end

    // payload and walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_val  <= i_in.item_value;
            r_sel  <= (i_in.mode == MODE_OFF);
            r_pos  <= (i_in.mode == MODE_OFF) ? r_off_cnt : r_req_cnt;
            r_a    <= '0;
            r_b    <= '0;
            r_hits <= '0;
        end
        if (i_cmd.shift) begin
            r_pos <= pos_m1;
        end
        if (i_cmd.run_cmp) begin
            if (diff <= r_tol) begin
                r_hits <= r_hits + 1'b1;
                r_a    <= r_a + 1'b1;
                r_b    <= r_b + 1'b1;
            end else if (req_rdata < off_rdata) begin
                r_a <= r_a + 1'b1;
            end else begin
                r_b <= r_b + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_res.match_count   <= r_hits;
            r_res.overflow_seen <= r_ovf;
        end
    end

    assign o_sts.full     = full_in;
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.gt       = (sel_rdata > r_val);
    assign o_sts.run_end  = (r_a >= r_req_cnt) || (r_b >= r_off_cnt);
    assign o_strobe       = r_strobe;
    assign o_res          = r_res;

endmodule

[rtl/core/stm_checker.sv]
module stm_checker
    import stm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_res_strobe,
    input t_out o_res
);

    // results never come back to back
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobe held two cycles");

    // a result follows a busy spell
    a_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result without a preceding run");

    // count cannot exceed list capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_res.match_count <= CNT_W'(MAX_REQUESTS)))
        else $error("match count out of range");

    // busy only rises after a word is offered
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a command");

    // reset leaves the block idle and silent
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!busy && !o_res_strobe))
        else $error("activity right after reset");

endmodule

bind sorted_tolerance_matcher_unit stm_checker u_stm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);

[dv/sorted_tolerance_matcher_unit_tb.sv]
module sorted_tolerance_matcher_unit_tb
    import stm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  RANDOM_WORDS = 450;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    // One row of the directed table: a command word, and where the answer is
    // obvious, the result typed in by hand.
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] value;
        bit          typed;
        t_out        answer;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in              i_cmd = '0;
    logic             o_res_strobe;
    t_out             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [VAL_W-1:0] i_cfg_data = '0;

    // Shadow state of the block
    logic [31:0] request_list[$];
    logic [31:0] offer_list[$];
    bit          dropped_load;
    logic [31:0] tol_shadow;

    t_out pending_counts[$];
    int   fails = 0;
    int   cycles = 0;
    int   idle_pct = 0;
    int   random_words = 0;

    sorted_tolerance_matcher_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: nothing correct comes near this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** sorted_tolerance_matcher_unit: FAILED **");
            $finish;
        end
    end

    task automatic report(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d got %0d (cycle %0d)", what, want, got, cycles);
        fails++;
    endtask

    // Check each result word against the oldest pending count. Outputs are
    // sampled at the edge, so they still hold the values of the ending cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (pending_counts.size() == 0) begin
                report("unexpected result, match_count", -1, o_res.match_count);
            end else begin
                t_out want;
                want = pending_counts.pop_front();
                if (o_res.match_count !== want.match_count)
                    report("match_count", want.match_count, o_res.match_count);
                if (o_res.overflow_seen !== want.overflow_seen)
                    report("overflow_seen", want.overflow_seen, o_res.overflow_seen);
            end
        end
    end

    // Insert into an ascending list; drop and flag when it is full.
    task automatic file_value(ref logic [31:0] lst[$], input int cap, input logic [31:0] v);
        int p;
        if (lst.size() >= cap) begin
            dropped_load = 1'b1;
        end else begin
            p = lst.size();
            while (p > 0 && lst[p-1] > v) p--;
            lst.insert(p, v);
        end
    endtask

    // Greedy two-pointer pairing within the tolerance.
    function automatic t_out pair_lists();
        int    a, b, hits;
        logic [31:0] gap;
        t_out  r;
        a = 0;
        b = 0;
        hits = 0;
        while (a < request_list.size() && b < offer_list.size()) begin
            gap = (request_list[a] > offer_list[b]) ? request_list[a] - offer_list[b]
                                                    : offer_list[b] - request_list[a];
            if (gap <= tol_shadow) begin
                hits++;
                a++;
                b++;
            end else if (request_list[a] < offer_list[b]) begin
                a++;
            end else begin
                b++;
            end
        end
        r.match_count   = hits[CNT_W-1:0];
        r.overflow_seen = dropped_load;
        return r;
    endfunction

    // Offer a word, hold until it is taken, then update the shadow state.
    // A run pushes either the typed answer or the predicted one.
    task automatic send_word(input logic [1:0] mode, input logic [31:0] value,
                             input bit typed = 0, input t_out answer = '0);
        t_out predicted;
        start <= 1'b1;
        i_cmd <= '{mode: mode, item_value: value};
        do @(posedge i_clk); while (busy);
        case (mode)
            MODE_REQ: file_value(request_list, MAX_REQUESTS, value);
            MODE_OFF: file_value(offer_list, MAX_OFFERS, value);
            MODE_RUN: begin
                predicted = pair_lists();
                pending_counts.push_back(typed ? answer : predicted);
                request_list.delete();
                offer_list.delete();
                dropped_load = 1'b0;
            end
            default: ;
        endcase
        // Idle the sender now and then so gaps land on every phase of the work
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    // Wait for every result, then let any trailing insert finish.
    task automatic drain();
        start <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_tolerance(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tol_shadow = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Well-formed burst: loads at a random base plus an offset within a chosen spread, then a run.
    task automatic send_batch();
        logic [31:0] base, spread;
        int n_req, n_off;
        base  = $urandom;
        case ($urandom_range(3))
            0: spread = 8;
            1: spread = 1000;
            2: spread = tol_shadow > 32'h7fff_ffff ? 32'hffff_ffff : tol_shadow * 2 + 1;
            default: spread = 32'hffff_ffff;
        endcase
        n_req = $urandom_range(12);
        n_off = $urandom_range(12);
        while (n_req > 0 || n_off > 0) begin
            if (n_off == 0 || (n_req > 0 && $urandom_range(1))) begin
                send_word(MODE_REQ, base + $urandom_range(spread));
                n_req--;
            end else begin
                send_word(MODE_OFF, base + $urandom_range(spread));
                n_off--;
            end
            random_words++;
        end
        send_word(MODE_RUN, $urandom);
        random_words++;
    endtask

    task automatic send_noise();
        logic [1:0] m;
        m = $urandom_range(3);
        send_word(m, $urandom);
        if (m != MODE_IGNORED) random_words++;
    endtask

    t_row rows[$];

    initial begin
        logic [31:0] phase_tol[4];
        int          phase_idle[4];

        dropped_load = 1'b0;
        tol_shadow   = '0;

        // Directed table; tolerance stays at its reset value of zero
        rows = '{
            '{MODE_RUN, 32'h0,         1, '{11'd0, 1'b0}},
            '{MODE_REQ, 32'h0,         0, '0},
            '{MODE_REQ, 32'hffff_ffff, 0, '0},
            '{MODE_OFF, 32'hffff_ffff, 0, '0},
            '{MODE_OFF, 32'h0,         0, '0},
            '{MODE_RUN, 32'hffff_ffff, 1, '{11'd2, 1'b0}},
            '{MODE_IGNORED, 32'h5a5a_a5a5, 0, '0},
            '{MODE_RUN, 32'h0,         1, '{11'd0, 1'b0}},
            '{MODE_REQ, 32'd5,         0, '0},
            '{MODE_OFF, 32'd7,         0, '0},
            '{MODE_RUN, 32'h0,         0, '0},
            '{MODE_REQ, 32'd10,        0, '0},
            '{MODE_REQ, 32'd3,         0, '0},
            '{MODE_REQ, 32'd7,         0, '0},
            '{MODE_OFF, 32'd7,         0, '0},
            '{MODE_OFF, 32'd3,         0, '0},
            '{MODE_OFF, 32'd11,        0, '0},
            '{MODE_RUN, 32'h0,         0, '0},
            '{MODE_REQ, 32'd1,         0, '0},
            '{MODE_RUN, 32'h0,         1, '{11'd0, 1'b0}},
            '{MODE_OFF, 32'd1,         0, '0},
            '{MODE_RUN, 32'h0,         1, '{11'd0, 1'b0}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].mode, rows[i].value, rows[i].typed, rows[i].answer);
        drain();

        phase_tol  = '{$urandom_range(64), 32'hffff_ffff, 32'h0, $urandom};
        phase_idle = '{0, 88, 17, 0};
        for (int ph = 0; ph < 4; ph++) begin
            set_tolerance(phase_tol[ph]);
            idle_pct = phase_idle[ph];
            while (random_words < RANDOM_WORDS * (ph + 1) / 4) begin
                if ($urandom_range(99) < 85) send_batch();
                else send_noise();
                // Late in phase 1, wait for all results after each step
                if (ph == 1 && random_words > RANDOM_WORDS * 3 / 8 && pending_counts.size() != 0)
                    drain();
            end
            send_word(MODE_RUN, 32'h0);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("** sorted_tolerance_matcher_unit: PASSED **");
        end else begin
            $display("** sorted_tolerance_matcher_unit: FAILED **");
        end
        $finish;
    end

endmodule
